// ----- rtl/bvsg_pkg.sv -----
`default_nettype none

package bvsg_pkg;

	localparam int ADDR_W = 18;

	// display base word address and the extra offset of the large memory model
	localparam logic [ADDR_W-1:0] BASE_WORD_ADDR = ADDR_W'((32'h12700 >> 1) | (32'h40 << 8));
	localparam logic [ADDR_W-1:0] LARGE_OFFSET   = ADDR_W'(32'h60000 >> 1);

	// raster decisions for one tick, from the timing unit to the datapath
	typedef struct packed {
		logic       draw;        // tick lies in the visible area
		logic       fetch;       // draw tick on a 16-pixel boundary
		logic       line_start;  // horizontal counter wraps after this tick
		logic [9:0] h_next;
		logic [8:0] v_next;
		logic       vblank_next;
		logic       hblank_next;
	} raster_t;

	// word address of the first display word of a line
	function automatic logic [ADDR_W-1:0] line_addr(input logic big_mem, input logic [8:0] line);
		logic [ADDR_W-1:0] base;
		base = big_mem ? (BASE_WORD_ADDR + LARGE_OFFSET) : BASE_WORD_ADDR;
		return base + {{(ADDR_W-14){1'b0}}, line, 5'b0};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bvsg_in_if.sv -----
`default_nettype none

interface bvsg_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] mem_word;

	modport source (output valid, output mem_word, input ready);
	modport sink (input valid, input mem_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/bvsg_out_if.sv -----
`default_nettype none

interface bvsg_out_if;
	logic        valid;
	logic        ready;
	logic        pixel_first;
	logic        pixel_second;
	logic        pixels_valid;
	logic        ram_busy;
	logic        vblank_irq;
	logic        in_hblank;
	logic [17:0] next_fetch_addr;
	logic [9:0]  h_position;
	logic [8:0]  v_position;

	modport source (output valid, output pixel_first, output pixel_second,
		output pixels_valid, output ram_busy, output vblank_irq, output in_hblank,
		output next_fetch_addr, output h_position, output v_position, input ready);
	modport sink (input valid, input pixel_first, input pixel_second,
		input pixels_valid, input ram_busy, input vblank_irq, input in_hblank,
		input next_fetch_addr, input h_position, input v_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/bvsg_cfg_if.sv -----
`default_nettype none

interface bvsg_cfg_if;
	logic valid;
	logic ready;
	logic large_memory_model;

	modport source (output valid, output large_memory_model, input ready);
	modport sink (input valid, input large_memory_model, output ready);
endinterface

`default_nettype wire

// ----- rtl/bvsg_raster.sv -----
`default_nettype none

module bvsg_raster
	import bvsg_pkg::*;
#(
	parameter int H_VISIBLE = 512,
	parameter int H_TOTAL   = 704,
	parameter int V_VISIBLE = 342,
	parameter int V_TOTAL   = 370
) (
	input  wire logic [9:0] hcount,
	input  wire logic [8:0] vcount,
	input  wire logic       vblank,
	output raster_t         rast
);

	localparam logic [10:0] HVIS = 11'(H_VISIBLE);
	localparam logic [10:0] HTOT = 11'(H_TOTAL);
	localparam logic [8:0]  VVIS = 9'(V_VISIBLE);
	localparam logic [8:0]  VTOT = 9'(V_TOTAL);

	logic [10:0] h_sum;
	logic [8:0]  v_inc;
	logic        v_set;
	logic        v_clr;

	// horizontal and vertical step, blanking marks
	always_comb begin
		h_sum = {1'b0, hcount} + 11'd2;
		v_inc = vcount + 9'd1;
		v_set = (v_inc == VVIS);
		v_clr = (v_inc >= VTOT);

		rast.draw        = !vblank && ({1'b0, hcount} < HVIS);
		rast.fetch       = rast.draw && (hcount[3:0] == 4'd0);
		rast.line_start  = (h_sum >= HTOT);
		rast.h_next      = rast.line_start ? 10'd0 : h_sum[9:0];
		rast.v_next      = vcount;
		rast.vblank_next = vblank;
		if (rast.line_start) begin
			rast.v_next = v_clr ? 9'd0 : v_inc;
			if (v_clr) begin
				rast.vblank_next = 1'b0;
			end else if (v_set) begin
				rast.vblank_next = 1'b1;
			end
		end
		rast.hblank_next = ({1'b0, rast.h_next} > HVIS);
	end

endmodule

`default_nettype wire

// ----- rtl/bitmap_video_scan_generator.sv -----
// channel | modport | word                  | role
// src     | sink    | mem_word              | display ram word at the last fetch address
// dst     | source  | pixels, flags, counts | one result per tick
// cfg     | sink    | large_memory_model    | base address select, held off while a word is taken
//
// one word per clock sustained while dst.ready is high; each result appears in
// the cycle after its word is taken, held in the output register, which is the
// only stage. the counter, shifter and address update is one pass of logic
// from the state registers into the output register.
// src.ready is high while the output register is empty or being emptied.
// reset clears counters, shifter, flags and sets the address to the line 0 base.
`default_nettype none

module bitmap_video_scan_generator
	import bvsg_pkg::*;
#(
	parameter int H_VISIBLE = 512,
	parameter int H_TOTAL   = 704,
	parameter int V_VISIBLE = 342,
	parameter int V_TOTAL   = 370
) (
	input wire logic clk,
	input wire logic arst_n,
	bvsg_in_if.sink    src,
	bvsg_out_if.source dst,
	bvsg_cfg_if.sink   cfg
);

	logic [9:0]        hcount_q;
	logic [8:0]        vcount_q;
	logic [15:0]       shifter_q;
	logic [ADDR_W-1:0] fetch_addr_q;
	logic              irq_q;
	logic              vblank_q;
	logic              contended_q;
	logic              large_q;
	logic              out_valid_q;

	raster_t           rast;
	logic              take;
	logic [15:0]       shift_src;
	logic [15:0]       shifter_d;
	logic [ADDR_W-1:0] addr_d;
	logic              contended_d;

	bvsg_raster #(
		.H_VISIBLE (H_VISIBLE),
		.H_TOTAL   (H_TOTAL),
		.V_VISIBLE (V_VISIBLE),
		.V_TOTAL   (V_TOTAL)
	) u_raster (
		.hcount (hcount_q),
		.vcount (vcount_q),
		.vblank (vblank_q),
		.rast   (rast)
	);

	// handshake; a register write waits while a word is taken
	assign src.ready = !out_valid_q || dst.ready;
	assign take      = src.valid && src.ready;
	assign cfg.ready = !take;

	// shifter load, pixel shift and fetch address
	always_comb begin
		shift_src   = rast.fetch ? src.mem_word : shifter_q;
		shifter_d   = rast.draw ? {shift_src[13:0], 2'b00} : shifter_q;
		addr_d      = rast.fetch ? (fetch_addr_q + ADDR_W'(1)) : fetch_addr_q;
		contended_d = rast.draw ? rast.fetch : contended_q;
		if (rast.line_start) begin
			addr_d = line_addr(large_q, rast.v_next);
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcount_q     <= '0;
			vcount_q     <= '0;
			shifter_q    <= '0;
			fetch_addr_q <= BASE_WORD_ADDR;
			irq_q        <= 1'b0;
			vblank_q     <= 1'b0;
			contended_q  <= 1'b0;
			large_q      <= 1'b0;
		end else if (take) begin
			hcount_q     <= rast.h_next;
			vcount_q     <= rast.v_next;
			shifter_q    <= shifter_d;
			fetch_addr_q <= addr_d;
			irq_q        <= rast.vblank_next;
			vblank_q     <= rast.vblank_next;
			contended_q  <= contended_d;
		end else if (cfg.valid) begin
			large_q <= cfg.large_memory_model;
			if (hcount_q == 10'd0) begin
				fetch_addr_q <= line_addr(cfg.large_memory_model, vcount_q);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (src.ready) begin
			out_valid_q <= src.valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			dst.pixel_first     <= rast.draw && shift_src[15];
			dst.pixel_second    <= rast.draw && shift_src[14];
			dst.pixels_valid    <= rast.draw;
			dst.ram_busy        <= contended_d;
			dst.vblank_irq      <= rast.vblank_next;
			dst.in_hblank       <= rast.hblank_next;
			dst.next_fetch_addr <= addr_d;
			dst.h_position      <= rast.h_next;
			dst.v_position      <= rast.v_next;
		end
	end

	assign dst.valid = out_valid_q;

	// interrupt level and blanking mark move together
	a_irq_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		irq_q == vblank_q) else $error("irq level and vblank mark differ");

	// a fetch tick leaves the contention flag set
	a_fetch_contends: assert property (@(posedge clk) disable iff (!arst_n)
		take && rast.fetch |=> contended_q) else $error("fetch without contention flag");

	// each line starts on a 32-word boundary
	a_line_align: assert property (@(posedge clk) disable iff (!arst_n)
		take && rast.line_start |=> fetch_addr_q[4:0] == 5'd0)
		else $error("line address not aligned");

	// horizontal position stays even and inside the line
	a_hcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		!hcount_q[0] && ({1'b0, hcount_q} < 11'(H_TOTAL)))
		else $error("horizontal counter out of range");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
	import bvsg_pkg::*;

	localparam int H_VISIBLE   = 512;
	localparam int H_TOTAL     = 704;
	localparam int V_VISIBLE   = 342;
	localparam int V_TOTAL     = 370;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int IDLE_PCT    = 29;
	localparam int BURST_FROM  = 500;
	localparam int BURST_TO    = 800;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 400;

	// one result word of the scan generator
	typedef struct packed {
		logic              pixel_first;
		logic              pixel_second;
		logic              pixels_valid;
		logic              ram_busy;
		logic              vblank_irq;
		logic              in_hblank;
		logic [ADDR_W-1:0] next_fetch_addr;
		logic [9:0]        h_position;
		logic [8:0]        v_position;
	} scan_result_t;

	// raster predictor and queue of expected tick results
	class scan_scoreboard;
		logic [9:0]        hpos;
		logic [8:0]        vpos;
		logic [15:0]       shifter;
		logic [ADDR_W-1:0] fetch_addr;
		logic              irq;
		logic              vblank_lines;
		logic              contended;
		logic              large_model;
		scan_result_t      pending_ticks[$];
		int unsigned       errors;

		function new();
			hpos         = '0;
			vpos         = '0;
			shifter      = '0;
			irq          = 1'b0;
			vblank_lines = 1'b0;
			contended    = 1'b0;
			large_model  = 1'b0;
			errors       = 0;
			fetch_addr   = line_base(9'd0);
		endfunction

		// first display word of a line, offset by the current column
		function logic [ADDR_W-1:0] line_base(logic [8:0] line);
			logic [ADDR_W-1:0] base;
			base = large_model ? BASE_WORD_ADDR + LARGE_OFFSET : BASE_WORD_ADDR;
			return base + ADDR_W'(hpos >> 4) + ADDR_W'({line, 5'b0});
		endfunction

		// register write; takes effect at once only at the start of a line
		function void set_large_model(logic big_mem);
			large_model = big_mem;
			if (hpos == 0)
				fetch_addr = line_base(vpos);
		endfunction

		// advance the raster by one two-pixel tick for an accepted word
		function void scan_tick(logic [15:0] word);
			scan_result_t r;
			int           h;
			r = '0;
			if (!vblank_lines && hpos < H_VISIBLE) begin
				if (hpos[3:0] == 4'd0) begin
					shifter    = word;
					fetch_addr = fetch_addr + 1'b1;
					contended  = 1'b1;
				end else begin
					contended = 1'b0;
				end
				r.pixel_first  = shifter[15];
				r.pixel_second = shifter[14];
				shifter        = shifter << 2;
				r.pixels_valid = 1'b1;
			end
			h = int'(hpos) + 2;
			if (h >= H_TOTAL) begin
				hpos = '0;
				vpos = vpos + 9'd1;
				if (vpos == V_VISIBLE) begin
					irq          = 1'b1;
					vblank_lines = 1'b1;
				end
				if (vpos >= V_TOTAL) begin
					irq          = 1'b0;
					vblank_lines = 1'b0;
					vpos         = '0;
				end
				fetch_addr = line_base(vpos);
			end else begin
				hpos = 10'(h);
			end
			r.ram_busy        = contended;
			r.vblank_irq      = irq;
			r.in_hblank       = (hpos > H_VISIBLE);
			r.next_fetch_addr = fetch_addr;
			r.h_position      = hpos;
			r.v_position      = vpos;
			pending_ticks.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		// match one result word against the oldest prediction
		function void check_tick(scan_result_t got);
			scan_result_t want;
			if (pending_ticks.size() == 0) begin
				$error("result word arrived with none expected");
				errors++;
				return;
			end
			want = pending_ticks.pop_front();
			compare("pixel_first", want.pixel_first, got.pixel_first);
			compare("pixel_second", want.pixel_second, got.pixel_second);
			compare("pixels_valid", want.pixels_valid, got.pixels_valid);
			compare("ram_busy", want.ram_busy, got.ram_busy);
			compare("vblank_irq", want.vblank_irq, got.vblank_irq);
			compare("in_hblank", want.in_hblank, got.in_hblank);
			compare("next_fetch_addr", want.next_fetch_addr, got.next_fetch_addr);
			compare("h_position", want.h_position, got.h_position);
			compare("v_position", want.v_position, got.v_position);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int unsigned words_sent = 0;
	int unsigned words_seen = 0;
	scan_scoreboard sb;

	bvsg_in_if  src_if();
	bvsg_out_if dst_if();
	bvsg_cfg_if cfg_if();

	bitmap_video_scan_generator #(
		.H_VISIBLE(H_VISIBLE),
		.H_TOTAL(H_TOTAL),
		.V_VISIBLE(V_VISIBLE),
		.V_TOTAL(V_TOTAL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_if),
		.dst(dst_if),
		.cfg(cfg_if)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// random idling, switched off over one long stretch of words
	function automatic bit gap_wanted(int unsigned count);
		if (count >= BURST_FROM && count < BURST_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	task automatic push_word(input logic [15:0] word);
		while (gap_wanted(words_sent)) begin
			src_if.valid <= 1'b0;
			@(posedge clk);
		end
		src_if.valid    <= 1'b1;
		src_if.mem_word <= word;
		do @(posedge clk); while (!src_if.ready);
		words_sent++;
		sb.scan_tick(word);
	endtask

	task automatic run_words(input int unsigned count);
		repeat (count) push_word(16'($urandom));
	endtask

	task automatic write_large_model(input logic big_mem);
		cfg_if.valid              <= 1'b1;
		cfg_if.large_memory_model <= big_mem;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.set_large_model(big_mem);
	endtask

	// wait until every expected result word has been checked
	task automatic settle();
		src_if.valid <= 1'b0;
		while (sb.pending_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned ticks_to_line_end();
		return (H_TOTAL - int'(sb.hpos)) / 2;
	endfunction

	// result side: random stalls plus one long hold-off to back up the input
	initial begin : result_sink
		scan_result_t got;
		int unsigned  held;
		bit           hold_done;
		held      = 0;
		hold_done = 1'b0;
		dst_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dst_if.valid === 1'b1 && dst_if.ready === 1'b1) begin
				got.pixel_first     = dst_if.pixel_first;
				got.pixel_second    = dst_if.pixel_second;
				got.pixels_valid    = dst_if.pixels_valid;
				got.ram_busy        = dst_if.ram_busy;
				got.vblank_irq      = dst_if.vblank_irq;
				got.in_hblank       = dst_if.in_hblank;
				got.next_fetch_addr = dst_if.next_fetch_addr;
				got.h_position      = dst_if.h_position;
				got.v_position      = dst_if.v_position;
				sb.check_tick(got);
				words_seen++;
			end
			if (!hold_done && words_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				held      = HOLD_CYCLES;
			end
			if (held != 0) begin
				held--;
				dst_if.ready <= 1'b0;
			end else begin
				dst_if.ready <= !gap_wanted(words_seen);
			end
		end
	end

	initial begin : stimulus
		logic [15:0] edge_words [4];
		edge_words = '{16'hFFFF, 16'h8000, 16'h0001, 16'h0000};
		sb = new();
		src_if.valid              <= 1'b0;
		src_if.mem_word           <= '0;
		cfg_if.valid              <= 1'b0;
		cfg_if.large_memory_model <= 1'b0;
		arst_n                    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fetch ticks load all ones, a lone msb, a lone lsb and all zeros
		for (int i = 0; i < 25; i++)
			push_word(edge_words[i / 8]);

		// write mid-line: the large base only shows from the next line
		settle();
		write_large_model(1'b1);
		run_words(ticks_to_line_end());

		// write at the start of a line: address recomputed at once
		settle();
		write_large_model(1'b0);
		run_words(200);

		// large base mid-line, carried into the next line
		settle();
		write_large_model(1'b1);
		run_words(ticks_to_line_end());
		run_words(100);

		// back to the small base mid-line, then large again at a line start
		settle();
		write_large_model(1'b0);
		run_words(ticks_to_line_end());
		settle();
		write_large_model(1'b1);
		run_words(50);

		settle();
		if (sb.errors == 0 && sb.pending_ticks.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bvsg_pkg.sv
rtl/bvsg_in_if.sv
rtl/bvsg_out_if.sv
rtl/bvsg_cfg_if.sv
rtl/bvsg_raster.sv
rtl/bitmap_video_scan_generator.sv
tb/testbench.sv
